[design/ttb_pkg.sv]
// ----------------------------------------------------------------------------
// ttb_pkg
// Shared constants, command codes and types of the tick timer bank.
// ----------------------------------------------------------------------------
package ttb_pkg;

  localparam int BANK_SIZE  = 8;
  localparam int TIDX_W     = $clog2(BANK_SIZE);
  localparam int TCNT_W     = $clog2(BANK_SIZE + 1);

  localparam int STEP_W     = 10;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;
  localparam int ACT_W      = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MS_PER_TICK   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_TIMERS = 1'd1;

  // Command codes
  localparam logic [2:0] CMD_TICK     = 3'd0;
  localparam logic [2:0] CMD_ARM      = 3'd1;
  localparam logic [2:0] CMD_READ     = 3'd2;
  localparam logic [2:0] CMD_ENABLE   = 3'd3;
  localparam logic [2:0] CMD_COUNTERS = 3'd4;

  // One timer entry: reload period and remaining time
  typedef struct packed {
    logic signed [31:0] period;
    logic signed [31:0] remain;
  } row_t;

  // Access request to the timer memory
  typedef struct packed {
    logic              we;
    logic [TIDX_W-1:0] waddr;
    row_t              wdata;
    logic [TIDX_W-1:0] raddr;
  } ram_req_t;

endpackage

[design/ttb_if.sv]
// ----------------------------------------------------------------------------
// ttb_if
// Valid/ready channels of the tick timer bank: command items in, results out.
// ----------------------------------------------------------------------------
interface ttb_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         command;
  logic [2:0]         timer_index;
  logic signed [31:0] duration_ms;
  logic               repeat_mode;
  logic               event_enable;

  modport source (output valid, command, timer_index, duration_ms, repeat_mode,
                  event_enable, input ready);
  modport sink   (input valid, command, timer_index, duration_ms, repeat_mode,
                  event_enable, output ready);
endinterface

interface ttb_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] remaining_ms;
  logic [7:0]         expired_mask;
  logic [31:0]        tick_count;
  logic [63:0]        elapsed_ms;
  logic               index_valid;

  modport source (output valid, remaining_ms, expired_mask, tick_count, elapsed_ms,
                  index_valid, input ready);
  modport sink   (input valid, remaining_ms, expired_mask, tick_count, elapsed_ms,
                  index_valid, output ready);
endinterface

[design/tick_timer_bank.sv]
// ----------------------------------------------------------------------------
// tick_timer_bank
// Tick and millisecond counters with a bank of countdown timers.
// ----------------------------------------------------------------------------
// Usage: each item on in_ch is one command (tick, arm, read timer, set event
// enable, read counters); every command yields exactly one item on out_ch,
// which carries the counters after the command, the remaining time on a
// timer read, the expiry mask on a tick and the index check result.
// Timer entries (remaining time and period) live in a synchronous memory
// with a registered read; a tick walks the active entries one per cycle,
// reading the next entry while writing back the current one.
// A tick with active timers walks them (at most 8) in the tick state, a
// read of a live timer passes the read state, and all else goes straight
// to the done state, which loads the result into the output register; only
// then does the block return to idle and accept the next command.
// Configuration (cfg_we, cfg_index, cfg_data) is to be written only while
// idle; the block itself does not enforce this.
// Reset clears counters, registers, enables and the entry valid bits, so
// every timer reads zero. When out_ch stalls, the finished item holds in
// the output register; one more command is taken and processed, and its
// result waits until the output register frees up.
// ----------------------------------------------------------------------------
module tick_timer_bank (
  input  logic                               clk,
  input  logic                               rst_n,
  ttb_in_if.sink                             in_ch,
  ttb_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [ttb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ttb_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import ttb_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_TICK = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]            state_r, state_nxt;
  logic [STEP_W-1:0]     ms_per_tick_r;
  logic [ACT_W-1:0]      active_timers_r;
  logic [31:0]           tick_cnt_r;
  logic [63:0]           ms_cnt_r;
  logic [BANK_SIZE-1:0]  ev_en_r;

  logic [TIDX_W-1:0]     wb_idx_r;
  logic [7:0]            mask_r;
  logic signed [31:0]    res_rem_r;
  logic                  res_iv_r;

  logic                  out_valid_r;
  logic signed [31:0]    out_rem_r;
  logic [7:0]            out_mask_r;
  logic [31:0]           out_tick_r;
  logic [63:0]           out_ms_r;
  logic                  out_iv_r;

  logic [TCNT_W-1:0]     live_n;
  logic                  accept;
  logic                  idx_ok;
  logic                  out_free;
  logic                  wb_last;
  ram_req_t              ram_req;
  row_t                  ram_rdata;
  logic signed [31:0]    calc_rem;
  logic                  calc_exp;

  ttb_timer_ram u_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  ttb_tick_calc u_calc (
    .row        (ram_rdata),
    .step       (ms_per_tick_r),
    .event_en   (ev_en_r[wb_idx_r]),
    .new_remain (calc_rem),
    .expired    (calc_exp)
  );

  // Cap the active count at the bank size
  assign live_n = ({{(32-ACT_W){1'b0}}, active_timers_r} > BANK_SIZE)
                  ? TCNT_W'(BANK_SIZE) : TCNT_W'(active_timers_r);

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign idx_ok      = {{(TCNT_W-TIDX_W){1'b0}}, in_ch.timer_index} < live_n;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign wb_last     = ({{(TCNT_W-TIDX_W){1'b0}}, wb_idx_r} == (live_n - 1'b1));

  // Memory access: arm writes at accept when its index is live; a tick reads
  // entry 0 at accept and then writes back entry k while reading entry k + 1.
  always_comb begin
    ram_req       = '0;
    ram_req.raddr = in_ch.timer_index;
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_ch.command == CMD_TICK) begin
          ram_req.raddr = '0;
        end
        if (accept && in_ch.command == CMD_ARM && idx_ok) begin
          ram_req.we           = 1'b1;
          ram_req.waddr        = in_ch.timer_index;
          ram_req.wdata.remain = in_ch.duration_ms;
          ram_req.wdata.period = in_ch.repeat_mode ? in_ch.duration_ms : 32'sd0;
        end
      end
      S_TICK: begin
        ram_req.we           = 1'b1;
        ram_req.waddr        = wb_idx_r;
        ram_req.wdata.period = ram_rdata.period;
        ram_req.wdata.remain = calc_rem;
        ram_req.raddr        = wb_idx_r + 1'b1;
      end
      default: begin
        ram_req.raddr = wb_idx_r;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_ch.command == CMD_TICK && live_n != '0) begin
            state_nxt = S_TICK;
          end else if (in_ch.command == CMD_READ && idx_ok) begin
            state_nxt = S_READ;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_TICK: begin
        if (wb_last) begin
          state_nxt = S_DONE;
        end
      end
      S_READ: state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state, counters and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      ms_per_tick_r   <= '0;
      active_timers_r <= '0;
      tick_cnt_r      <= '0;
      ms_cnt_r        <= '0;
      ev_en_r         <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MS_PER_TICK:   ms_per_tick_r   <= cfg_data[STEP_W-1:0];
          CFG_ACTIVE_TIMERS: active_timers_r <= cfg_data[ACT_W-1:0];
          default: ;
        endcase
      end
      if (accept && in_ch.command == CMD_TICK) begin
        tick_cnt_r <= tick_cnt_r + 32'd1;
        ms_cnt_r   <= ms_cnt_r + {{(64-STEP_W){1'b0}}, ms_per_tick_r};
      end
      if (accept && in_ch.command == CMD_ENABLE && idx_ok) begin
        ev_en_r[in_ch.timer_index] <= in_ch.event_enable;
      end
      // Drop the result once taken; load the next one when the slot frees
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Per-command working values and the output register
  always_ff @(posedge clk) begin
    if (accept) begin
      wb_idx_r  <= '0;
      mask_r    <= '0;
      res_rem_r <= '0;
      res_iv_r  <= idx_ok && (in_ch.command == CMD_ARM || in_ch.command == CMD_READ ||
                              in_ch.command == CMD_ENABLE);
    end
    if (state_r == S_TICK) begin
      wb_idx_r <= wb_idx_r + 1'b1;
      if (calc_exp) begin
        mask_r[wb_idx_r] <= 1'b1;
      end
    end
    if (state_r == S_READ) begin
      res_rem_r <= ram_rdata.remain;
    end
    if (state_r == S_DONE && out_free) begin
      out_rem_r  <= res_rem_r;
      out_mask_r <= mask_r;
      out_tick_r <= tick_cnt_r;
      out_ms_r   <= ms_cnt_r;
      out_iv_r   <= res_iv_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.remaining_ms = out_rem_r;
  assign out_ch.expired_mask = out_mask_r;
  assign out_ch.tick_count   = out_tick_r;
  assign out_ch.elapsed_ms   = out_ms_r;
  assign out_ch.index_valid  = out_iv_r;

endmodule

[design/ttb_timer_ram.sv]
// ----------------------------------------------------------------------------
// ttb_timer_ram
// Timer entry memory: one write and one registered read per cycle, with a
// valid bit per row so that unwritten rows read as zero after reset.
// ----------------------------------------------------------------------------
module ttb_timer_ram (
  input  logic              clk,
  input  logic              rst_n,
  input  ttb_pkg::ram_req_t req,
  output ttb_pkg::row_t     rdata
);
  import ttb_pkg::*;

  row_t                  mem [BANK_SIZE];
  logic [BANK_SIZE-1:0]  row_vld_r;
  row_t                  rd_data_r;
  logic                  rd_vld_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_data_r <= mem[req.raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (req.we) begin
        row_vld_r[req.waddr] <= 1'b1;
      end
      rd_vld_r <= row_vld_r[req.raddr];
    end
  end

  assign rdata = rd_vld_r ? rd_data_r : '0;

endmodule

[design/ttb_tick_calc.sv]
// ----------------------------------------------------------------------------
// ttb_tick_calc
// Tick update of one timer entry: count down, clamp at zero, reload, flag.
// ----------------------------------------------------------------------------
module ttb_tick_calc (
  input  ttb_pkg::row_t             row,
  input  logic [ttb_pkg::STEP_W-1:0] step,
  input  logic                      event_en,
  output logic signed [31:0]        new_remain,
  output logic                      expired
);
  import ttb_pkg::*;

  logic        is_zero;
  logic        is_pos;
  logic [32:0] diff;
  logic        reach;

  always_comb begin
    is_zero = (row.remain == 32'sd0);
    is_pos  = !row.remain[31] && !is_zero;
    diff    = {row.remain[31], row.remain} - {{(33-STEP_W){1'b0}}, step};
    // a running timer reaches zero when the step covers what is left
    reach   = is_pos && (diff[32] || (diff == 33'd0));
    expired = reach && event_en;
    if (is_pos && !reach) begin
      new_remain = diff[31:0];
    end else if (reach || is_zero) begin
      new_remain = row.period;
    end else begin
      new_remain = row.remain;
    end
  end

endmodule

[tb/sv/ttb_checker.sv]
// ----------------------------------------------------------------------------
// ttb_checker
// Watches the command and result channels and the register writes of the
// tick timer bank. It keeps its own copy of the counters, timers and
// registers, works out the result of every accepted command and compares
// each delivered result with the oldest one still owed.
// ----------------------------------------------------------------------------
module ttb_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  ttb_in_if                              in_mon,
  ttb_out_if                             out_mon,
  input  logic                           cfg_we,
  input  logic [ttb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ttb_pkg::CFG_DATA_W-1:0] cfg_data,
  output int unsigned                    mismatches,
  output int unsigned                    results_seen,
  output int unsigned                    expiries_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  import ttb_pkg::*;

  typedef struct packed {
    logic signed [31:0] remaining_ms;
    logic [7:0]         expired_mask;
    logic [31:0]        tick_count;
    logic [63:0]        elapsed_ms;
    logic               index_valid;
  } bank_result_t;

  // Register copies
  logic [STEP_W-1:0]  step_ms;
  logic [ACT_W-1:0]   live_cfg;

  // Block state copies
  logic [31:0]        ticks;
  logic [63:0]        ms_total;
  logic signed [31:0] remain_ms [BANK_SIZE];
  logic signed [31:0] reload_ms [BANK_SIZE];
  logic               flag_en   [BANK_SIZE];

  bank_result_t       owed_results [$];
  int unsigned        fails   = 0;
  int unsigned        flagged = 0;

  assign mismatches    = fails;
  assign expiries_seen = flagged;

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] result %0d: %s got %0h, predicted %0h",
             $time, results_seen, what, got, want);
    fails++;
  endtask

  // Apply one command to the state copy and return its result.
  function automatic bank_result_t run_command(logic [2:0] cmd, logic [2:0] idx,
                                               logic signed [31:0] dur, logic rep,
                                               logic en);
    bank_result_t res;
    int           n;
    logic         hit;
    longint       left;
    res = '0;
    n   = (int'(live_cfg) > BANK_SIZE) ? BANK_SIZE : int'(live_cfg);
    hit = int'(idx) < n;
    case (cmd)
      CMD_TICK: begin
        ticks    = ticks + 32'd1;
        ms_total = ms_total + 64'(step_ms);
        // count down running timers, flag the ones that land on zero
        for (int i = 0; i < n; i++) begin
          if (remain_ms[i] > 0) begin
            left = longint'(remain_ms[i]) - longint'(step_ms);
            if (left <= 0) begin
              remain_ms[i] = '0;
              if (flag_en[i]) res.expired_mask[i] = 1'b1;
            end else begin
              remain_ms[i] = left[31:0];
            end
          end
        end
        // reload everything that stands at zero
        for (int i = 0; i < n; i++) begin
          if (remain_ms[i] == 0) remain_ms[i] = reload_ms[i];
        end
      end
      CMD_ARM, CMD_READ, CMD_ENABLE: begin
        res.index_valid = hit;
        if (hit) begin
          if (cmd == CMD_ARM) begin
            remain_ms[idx] = dur;
            reload_ms[idx] = rep ? dur : '0;
          end else if (cmd == CMD_READ) begin
            res.remaining_ms = remain_ms[idx];
          end else begin
            flag_en[idx] = en;
          end
        end
      end
      default: ;
    endcase
    res.tick_count = ticks;
    res.elapsed_ms = ms_total;
    return res;
  endfunction

  always @(posedge clk) begin
    bank_result_t want;
    if (!rst_n) begin
      step_ms  = '0;
      live_cfg = '0;
      ticks    = '0;
      ms_total = '0;
      for (int i = 0; i < BANK_SIZE; i++) begin
        remain_ms[i] = '0;
        reload_ms[i] = '0;
        flag_en[i]   = 1'b0;
      end
      owed_results.delete();
      results_seen <= 0;
    end else begin
      // Compare first: a result always belongs to an earlier command.
      if (out_mon.valid && out_mon.ready) begin
        results_seen <= results_seen + 1;
        if (owed_results.size() == 0) begin
          report_mismatch("result with nothing owed, tick_count", 64'(out_mon.tick_count), '0);
        end else begin
          want = owed_results.pop_front();
          if (want.expired_mask != '0) flagged++;
          if (out_mon.remaining_ms !== want.remaining_ms)
            report_mismatch("remaining_ms", 64'(out_mon.remaining_ms), 64'(want.remaining_ms));
          if (out_mon.expired_mask !== want.expired_mask)
            report_mismatch("expired_mask", 64'(out_mon.expired_mask), 64'(want.expired_mask));
          if (out_mon.tick_count !== want.tick_count)
            report_mismatch("tick_count", 64'(out_mon.tick_count), 64'(want.tick_count));
          if (out_mon.elapsed_ms !== want.elapsed_ms)
            report_mismatch("elapsed_ms", out_mon.elapsed_ms, want.elapsed_ms);
          if (out_mon.index_valid !== want.index_valid)
            report_mismatch("index_valid", 64'(out_mon.index_valid), 64'(want.index_valid));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        owed_results.push_back(run_command(in_mon.command, in_mon.timer_index,
                                           in_mon.duration_ms, in_mon.repeat_mode,
                                           in_mon.event_enable));
      end
      if (cfg_we) begin
        if (cfg_index == CFG_MS_PER_TICK) step_ms = cfg_data[STEP_W-1:0];
        else if (cfg_index == CFG_ACTIVE_TIMERS) live_cfg = cfg_data[ACT_W-1:0];
      end
    end
  end

endmodule

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Testbench top of the tick timer bank. It resets the block, walks it through
// a directed set of commands and then through phases of random commands under
// several register settings, with bursty command traffic and a result side
// that stalls on its own pattern. The checker beside the block predicts and
// compares every result; this module drives stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ttb_pkg::*;

  localparam int PHASES       = 9;
  localparam int PHASE_ITEMS  = 100;   // random commands per register setting
  localparam int IDLE_LIMIT   = 2000;  // cycles without any handshake or write
  localparam int SETTLE_CYCLES = 20;

  logic                  clk   = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ttb_in_if  in_ch ();
  ttb_out_if out_ch ();

  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned expiries_seen;

  // Sender bookkeeping
  int unsigned sent         = 0;
  int unsigned burst_left   = 0;
  int unsigned settings_run = 0;
  int unsigned cmd_sent [8];

  // Register settings of the random phases: extremes, a shrink of the
  // active count, a count above the bank size and a zero step among them.
  int unsigned step_plan [PHASES] = '{5, 1000, 0, 1, 1023, 7, 250, 3, 40};
  int unsigned live_plan [PHASES] = '{8, 3,    8, 15, 8,   1, 0,   5, 8};

  // Receiver stall state, private to the stall process
  int unsigned stall_mode = 0;
  int unsigned mode_left  = 0;
  logic [7:0]  stall_pat  = 8'h5b;

  int unsigned idle_cycles = 0;

  tick_timer_bank u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ttb_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .results_seen  (results_seen),
    .expiries_seen (expiries_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: switch between stall patterns at random intervals.
  // Modes: always ready, mostly ready, mostly stalled, rotating bit pattern.
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(20, 200);
      stall_pat  = 8'($urandom) | 8'h01;
    end else begin
      mode_left = mode_left - 1;
    end
    case (stall_mode)
      0:       out_ch.ready <= 1'b1;
      1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
      2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
      default: begin
        out_ch.ready <= stall_pat[0];
        stall_pat = {stall_pat[0], stall_pat[7:1]};
      end
    endcase
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[%0t] no handshake for %0d cycles", $time, IDLE_LIMIT);
      $display("** tick_timer_bank: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Present one command and hold it until accepted. Open a new burst,
  // possibly after a gap, when the current one runs out. Leave valid
  // high on return: the next caller either replaces the item or drops it.
  task automatic send_cmd(logic [2:0] cmd, logic [2:0] idx, logic signed [31:0] dur,
                          logic rep, logic en);
    int unsigned gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 7))
        0, 1:    gap = 0;
        7:       gap = $urandom_range(20, 40);
        default: gap = $urandom_range(1, 8);
      endcase
      // now and then a long stretch with no gaps at all
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_ch.valid        <= 1'b1;
    in_ch.command      <= cmd;
    in_ch.timer_index  <= idx;
    in_ch.duration_ms  <= dur;
    in_ch.repeat_mode  <= rep;
    in_ch.event_enable <= en;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
    sent++;
    cmd_sent[cmd]++;
  endtask

  // Drop valid and hold off until every owed result has come back.
  task automatic drain();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (results_seen < sent) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Write both registers; only called with the block idle.
  task automatic write_regs(int unsigned step, int unsigned live);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MS_PER_TICK;
    cfg_data  <= CFG_DATA_W'(step);
    @(posedge clk);
    cfg_index <= CFG_ACTIVE_TIMERS;
    cfg_data  <= CFG_DATA_W'(live);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_run++;
  endtask

  // One random command. Durations are mostly a few ticks long so that
  // timers expire often; the rest are zero, negative, extreme or raw.
  task automatic send_random(int unsigned step, int unsigned live);
    int unsigned        pick;
    int unsigned        n;
    logic [2:0]         cmd;
    logic [2:0]         idx;
    logic signed [31:0] dur;
    pick = $urandom_range(0, 99);
    if (pick < 40)      cmd = CMD_TICK;
    else if (pick < 58) cmd = CMD_ARM;
    else if (pick < 73) cmd = CMD_READ;
    else if (pick < 85) cmd = CMD_ENABLE;
    else if (pick < 93) cmd = CMD_COUNTERS;
    else                cmd = 3'($urandom_range(CMD_COUNTERS + 1, 7));
    n = (live > BANK_SIZE) ? BANK_SIZE : live;
    // mostly address live timers, sometimes any index
    if (n > 0 && $urandom_range(0, 4) != 0) idx = 3'($urandom_range(0, n - 1));
    else                                    idx = 3'($urandom_range(0, 7));
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: dur = $urandom_range(1, 6 * step + 2);
      6:                dur = '0;
      7:                dur = -int'($urandom_range(1, 100));
      8: begin
        case ($urandom_range(0, 3))
          0:       dur = 32'sh7fff_ffff;
          1:       dur = 32'sh8000_0000;
          2:       dur = -32'sd1;
          default: dur = 32'sd1;
        endcase
      end
      default:          dur = $urandom;
    endcase
    send_cmd(cmd, idx, dur, 1'($urandom), 1'($urandom));
  endtask

  initial begin
    // Drive every block input to a known value before the first edge.
    in_ch.valid        = 1'b0;
    in_ch.command      = CMD_TICK;
    in_ch.timer_index  = '0;
    in_ch.duration_ms  = '0;
    in_ch.repeat_mode  = 1'b0;
    in_ch.event_enable = 1'b0;
    out_ch.ready       = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_MS_PER_TICK;
    cfg_data           = '0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- Directed: full bank, one second per tick ----
    write_regs(1000, 8);
    send_cmd(CMD_COUNTERS, 3'd0, 32'sd0, 1'b0, 1'b0);
    send_cmd(CMD_READ,     3'd0, 32'sd0, 1'b0, 1'b0);        // timer untouched since reset
    send_cmd(CMD_ARM,      3'd0, 32'sd2500, 1'b1, 1'b0);     // periodic, expires on third tick
    send_cmd(CMD_ENABLE,   3'd0, 32'sd0, 1'b0, 1'b1);
    send_cmd(CMD_ARM,      3'd1, 32'sd1000, 1'b0, 1'b0);     // one-shot, expires on first tick
    send_cmd(CMD_ENABLE,   3'd1, 32'sd0, 1'b0, 1'b1);
    send_cmd(CMD_ARM,      3'd2, -32'sd5, 1'b1, 1'b0);       // negative periodic: never counts
    send_cmd(CMD_ARM,      3'd3, 32'sh7fff_ffff, 1'b0, 1'b1);
    send_cmd(CMD_ARM,      3'd4, 32'sd0, 1'b1, 1'b0);        // sits at zero, never flagged
    send_cmd(CMD_ARM,      3'd7, 32'sh8000_0000, 1'b1, 1'b1);
    send_cmd(CMD_ENABLE,   3'd7, 32'sd0, 1'b0, 1'b1);
    repeat (3) send_cmd(CMD_TICK, 3'd0, 32'sd0, 1'b0, 1'b0);
    send_cmd(CMD_READ, 3'd0, 32'sd0, 1'b0, 1'b0);
    send_cmd(CMD_READ, 3'd1, 32'sd0, 1'b0, 1'b0);
    send_cmd(CMD_READ, 3'd2, 32'sd0, 1'b0, 1'b0);
    send_cmd(CMD_READ, 3'd3, 32'sd0, 1'b0, 1'b0);
    send_cmd(CMD_READ, 3'd7, 32'sd0, 1'b0, 1'b0);
    // unused codes carry only the counters
    for (int c = CMD_COUNTERS + 1; c < 8; c++)
      send_cmd(3'(c), 3'($urandom), $urandom, 1'($urandom), 1'($urandom));
    send_cmd(CMD_ENABLE, 3'd0, 32'sd0, 1'b0, 1'b0);
    send_cmd(CMD_TICK,   3'd0, 32'sd0, 1'b0, 1'b0);

    // ---- Directed: shrink to three timers, out-of-range accesses ----
    drain();
    write_regs(1000, 3);
    send_cmd(CMD_ARM,    3'd5, 32'sd77, 1'b1, 1'b0);         // ignored
    send_cmd(CMD_READ,   3'd7, 32'sd0, 1'b0, 1'b0);          // reads zero
    send_cmd(CMD_ENABLE, 3'd6, 32'sd0, 1'b0, 1'b1);          // ignored
    send_cmd(CMD_TICK,   3'd0, 32'sd0, 1'b0, 1'b0);          // upper timers frozen

    // ---- Directed: zero step, active count above the bank size ----
    drain();
    write_regs(0, 15);
    send_cmd(CMD_TICK, 3'd0, 32'sd0, 1'b0, 1'b0);
    send_cmd(CMD_READ, 3'd7, 32'sd0, 1'b0, 1'b0);

    // ---- Random phases, one register setting each ----
    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_regs(step_plan[p], live_plan[p]);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // hold off mid-phase once until the bank has answered everything
        if (p == 4 && k == PHASE_ITEMS / 2) drain();
        send_random(step_plan[p], live_plan[p]);
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d commands: %0d ticks, %0d arms, %0d reads, %0d enables, %0d counter reads, %0d unused codes",
             sent, cmd_sent[CMD_TICK], cmd_sent[CMD_ARM], cmd_sent[CMD_READ],
             cmd_sent[CMD_ENABLE], cmd_sent[CMD_COUNTERS],
             cmd_sent[5] + cmd_sent[6] + cmd_sent[7]);
    $display("Used %0d register settings; %0d results checked, %0d ticks flagged an expiry",
             settings_run, results_seen, expiries_seen);
    if (mismatches == 0) begin
      $display("** tick_timer_bank: PASSED **");
    end else begin
      $display("** tick_timer_bank: FAILED **");
    end
    $finish;
  end

endmodule
